### hw/rtl/rrdt_pkg.sv
// Shared types, constants and the microcode table of the round-robin delay task table.
// Used by rrdt_seq and round_robin_delay_task_table; it has no dependencies of its own.
package rrdt_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int SLOT_IDX_W = 3;
   localparam int HANDLE_W = 16;
   localparam int TICKS_W = 16;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [TICKS_W-1:0] ticks_type;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_TICK     = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_FIND     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NONE       = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   // Microcode addresses.
   typedef enum logic [1:0] {
      UPC_FETCH  = 2'd0,
      UPC_SCREEN = 2'd1,
      UPC_SCAN   = 2'd2,
      UPC_EMIT   = 2'd3
   } upc_type;

   // Jump conditions that a control word can test.
   typedef enum logic [1:0] {
      COND_REQ  = 2'd0,
      COND_BAD  = 2'd1,
      COND_DONE = 2'd2,
      COND_RSP  = 2'd3
   } cond_type;

   // Datapath enables of one microcode step.
   typedef struct packed {
      logic load;
      logic screen;
      logic scan;
      logic emit;
   } ctrl_type;

   // Condition flags from the datapath to the sequencer.
   typedef struct packed {
      logic req_fire;
      logic bad_handle;
      logic scan_done;
      logic rsp_fire;
   } flags_type;

   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      upc_type  seq_next;
      upc_type  jump;
   } uword_type;

   // The control store: when the tested condition is true the step jumps,
   // otherwise it goes to its sequential successor.
   function automatic uword_type ucode(input upc_type addr);
      uword_type w;
      w = '{ctrl: '0, cond: COND_REQ, seq_next: UPC_FETCH, jump: UPC_FETCH};
      case (addr)
         UPC_FETCH: begin
            w.ctrl.load = 1'b1;
            w.cond      = COND_REQ;
            w.seq_next  = UPC_FETCH;
            w.jump      = UPC_SCREEN;
         end
         UPC_SCREEN: begin
            w.ctrl.screen = 1'b1;
            w.cond        = COND_BAD;
            w.seq_next    = UPC_SCAN;
            w.jump        = UPC_EMIT;
         end
         UPC_SCAN: begin
            w.ctrl.scan = 1'b1;
            w.cond      = COND_DONE;
            w.seq_next  = UPC_SCAN;
            w.jump      = UPC_EMIT;
         end
         UPC_EMIT: begin
            w.ctrl.emit = 1'b1;
            w.cond      = COND_RSP;
            w.seq_next  = UPC_EMIT;
            w.jump      = UPC_FETCH;
         end
         default: begin
            w.cond = COND_REQ;
         end
      endcase
      return w;
   endfunction

   // Round-robin successor of a slot number.
   function automatic slot_type next_slot(input slot_type s);
      slot_type n;
      if (s == SLOT_W'(TASK_SLOTS - 1)) begin
         n = '0;
      end else begin
         n = s + SLOT_W'(1);
      end
      return n;
   endfunction

endpackage

### hw/rtl/rrdt_if.sv
// Request and response channel interfaces of the round-robin delay task table.
// Field widths come from rrdt_pkg.
interface rrdt_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [rrdt_pkg::HANDLE_W-1:0] task_handle;
   logic [rrdt_pkg::TICKS_W-1:0]  delay_ticks;
   logic [rrdt_pkg::TICKS_W-1:0]  repeat_ticks;

   modport source (output valid, opcode, task_handle, delay_ticks, repeat_ticks,
                   input ready);
   modport sink (input valid, opcode, task_handle, delay_ticks, repeat_ticks,
                 output ready);
endinterface

interface rrdt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [rrdt_pkg::SLOT_IDX_W-1:0] slot_index;
   logic [rrdt_pkg::HANDLE_W-1:0]   run_handle;

   modport source (output valid, status, slot_index, run_handle, input ready);
   modport sink (input valid, status, slot_index, run_handle, output ready);
endinterface

### hw/rtl/rrdt_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on rrdt_pkg for the control word, flag and address types.
module rrdt_seq (
   input  logic                clock,
   input  logic                reset,
   input  rrdt_pkg::flags_type flags,
   output rrdt_pkg::ctrl_type  ctrl
);

   rrdt_pkg::upc_type   upc_ff;
   rrdt_pkg::upc_type   upc_in;
   rrdt_pkg::uword_type uword;
   logic                take_jump;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= rrdt_pkg::UPC_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      uword = rrdt_pkg::ucode(upc_ff);
      case (uword.cond)
         rrdt_pkg::COND_REQ:  take_jump = flags.req_fire;
         rrdt_pkg::COND_BAD:  take_jump = flags.bad_handle;
         rrdt_pkg::COND_DONE: take_jump = flags.scan_done;
         rrdt_pkg::COND_RSP:  take_jump = flags.rsp_fire;
         default:             take_jump = 1'b0;
      endcase
      upc_in = take_jump ? uword.jump : uword.seq_next;
      ctrl   = uword.ctrl;
   end

endmodule

### hw/rtl/round_robin_delay_task_table.sv
// A table of TASK_SLOTS task slots, each holding a handle, a countdown delay and a repeat
// period. One request word is taken at a time and answered by exactly one response word.
// A request takes one fetch step, one handle screening step, up to TASK_SLOTS scan steps
// and one step that presents the response until it is taken; the scan visits one slot
// per cycle. An add or find with an invalid handle skips the scan. Tick, an add to a full
// table and a dispatch or find that comes up empty scan every slot. Reset clears all
// slots and the round-robin pointer at once; the next request can be taken right after.
// Depends on rrdt_pkg, rrdt_if.sv and rrdt_seq.
module round_robin_delay_task_table (
   input  logic              clock,
   input  logic              reset,
   rrdt_req_if.sink          req_chan,
   rrdt_rsp_if.source        rsp_chan
);

   localparam int N = rrdt_pkg::TASK_SLOTS;

   rrdt_pkg::ctrl_type   ctrl;
   rrdt_pkg::flags_type  flags;

   rrdt_pkg::handle_type slot_handle_ff [N];
   rrdt_pkg::handle_type slot_handle_in [N];
   rrdt_pkg::ticks_type  slot_delay_ff  [N];
   rrdt_pkg::ticks_type  slot_delay_in  [N];
   rrdt_pkg::ticks_type  slot_repeat_ff [N];
   rrdt_pkg::ticks_type  slot_repeat_in [N];
   rrdt_pkg::slot_type   last_served_ff;
   rrdt_pkg::slot_type   last_served_in;

   rrdt_pkg::op_type     op_ff, op_in;
   rrdt_pkg::handle_type handle_ff, handle_in;
   rrdt_pkg::ticks_type  delay_ff, delay_in;
   rrdt_pkg::ticks_type  repeat_ff, repeat_in;
   rrdt_pkg::slot_type   idx_ff, idx_in;
   rrdt_pkg::slot_type   cnt_ff, cnt_in;

   rrdt_pkg::status_type status_ff, status_in;
   rrdt_pkg::slot_type   slot_ff, slot_in;
   rrdt_pkg::handle_type run_ff, run_in;

   rrdt_pkg::handle_type cur_handle;
   rrdt_pkg::ticks_type  cur_delay;
   rrdt_pkg::ticks_type  cur_repeat;
   logic                 hit;
   logic                 last;

   rrdt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign req_chan.ready      = ctrl.load;
   assign rsp_chan.valid      = ctrl.emit;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.slot_index = rrdt_pkg::SLOT_IDX_W'(slot_ff);
   assign rsp_chan.run_handle = run_ff;

   assign cur_handle = slot_handle_ff[idx_ff];
   assign cur_delay  = slot_delay_ff[idx_ff];
   assign cur_repeat = slot_repeat_ff[idx_ff];
   assign last       = (cnt_ff == rrdt_pkg::SLOT_W'(N - 1));

   always_comb begin
      case (op_ff)
         rrdt_pkg::OP_ADD:      hit = (cur_handle == '0);
         rrdt_pkg::OP_TICK:     hit = 1'b0;
         rrdt_pkg::OP_DISPATCH: hit = (cur_handle != '0) && (cur_delay == '0);
         rrdt_pkg::OP_FIND:     hit = (cur_handle == handle_ff);
         default:               hit = 1'b0;
      endcase
   end

   always_comb begin
      flags.req_fire   = req_chan.valid && ctrl.load;
      flags.bad_handle = ((op_ff == rrdt_pkg::OP_ADD) || (op_ff == rrdt_pkg::OP_FIND))
                         && (handle_ff == '0);
      flags.scan_done  = hit || last;
      flags.rsp_fire   = ctrl.emit && rsp_chan.ready;
   end

   always_comb begin
      slot_handle_in = slot_handle_ff;
      slot_delay_in  = slot_delay_ff;
      slot_repeat_in = slot_repeat_ff;
      last_served_in = last_served_ff;
      op_in          = op_ff;
      handle_in      = handle_ff;
      delay_in       = delay_ff;
      repeat_in      = repeat_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      status_in      = status_ff;
      slot_in        = slot_ff;
      run_in         = run_ff;

      if (flags.req_fire) begin
         op_in     = rrdt_pkg::op_type'(req_chan.opcode);
         handle_in = req_chan.task_handle;
         delay_in  = req_chan.delay_ticks;
         repeat_in = req_chan.repeat_ticks;
         cnt_in    = '0;
         // Dispatch starts one slot past the last one served; the others start at slot zero.
         if (rrdt_pkg::op_type'(req_chan.opcode) == rrdt_pkg::OP_DISPATCH) begin
            idx_in = rrdt_pkg::next_slot(last_served_ff);
         end else begin
            idx_in = '0;
         end
      end

      if (ctrl.screen && flags.bad_handle) begin
         status_in = rrdt_pkg::ST_BAD_HANDLE;
         slot_in   = '0;
         run_in    = '0;
      end

      if (ctrl.scan) begin
         if ((op_ff == rrdt_pkg::OP_TICK) && (cur_delay != '0)) begin
            slot_delay_in[idx_ff] = cur_delay - rrdt_pkg::TICKS_W'(1);
         end
         if (hit) begin
            status_in = rrdt_pkg::ST_OK;
            slot_in   = idx_ff;
            run_in    = '0;
            if (op_ff == rrdt_pkg::OP_ADD) begin
               slot_handle_in[idx_ff] = handle_ff;
               slot_delay_in[idx_ff]  = delay_ff;
               slot_repeat_in[idx_ff] = repeat_ff;
            end else if (op_ff == rrdt_pkg::OP_DISPATCH) begin
               run_in         = cur_handle;
               last_served_in = idx_ff;
               if (cur_repeat != '0) begin
                  slot_delay_in[idx_ff] = cur_repeat;
               end else begin
                  slot_handle_in[idx_ff] = '0;
                  slot_delay_in[idx_ff]  = '0;
                  slot_repeat_in[idx_ff] = '0;
               end
            end
         end else if (last) begin
            slot_in = '0;
            run_in  = '0;
            case (op_ff)
               rrdt_pkg::OP_ADD:  status_in = rrdt_pkg::ST_FULL;
               rrdt_pkg::OP_TICK: status_in = rrdt_pkg::ST_OK;
               default:           status_in = rrdt_pkg::ST_NONE;
            endcase
         end else begin
            idx_in = rrdt_pkg::next_slot(idx_ff);
            cnt_in = cnt_ff + rrdt_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            slot_handle_ff[i] <= '0;
            slot_delay_ff[i]  <= '0;
            slot_repeat_ff[i] <= '0;
         end
         last_served_ff <= '0;
      end else begin
         slot_handle_ff <= slot_handle_in;
         slot_delay_ff  <= slot_delay_in;
         slot_repeat_ff <= slot_repeat_in;
         last_served_ff <= last_served_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      handle_ff <= handle_in;
      delay_ff  <= delay_in;
      repeat_ff <= repeat_in;
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      run_ff    <= run_in;
   end

   // Only one request is in flight, so a pending response blocks new requests.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while a response is pending");

   // A failed request reports no slot and no handle.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (status_ff != rrdt_pkg::ST_OK))
      |-> ((slot_ff == '0) && (run_ff == '0)))
      else $error("failed request carries a slot or handle");

   // Only a dispatch hands out a task handle.
   a_run_only_dispatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (run_ff != '0)) |-> (op_ff == rrdt_pkg::OP_DISPATCH))
      else $error("run handle on a request other than dispatch");

   // The sequencer comes out of reset ready for a request.
   a_reset_fetch: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_chan.ready)
      else $error("sequencer not at fetch after reset");

endmodule

### tb/tb.sv
// Self-checking testbench for round_robin_delay_task_table: random and directed
// request words, a per-request table predictor and a response checker.
// Depends on rrdt_pkg and the channel interfaces in rrdt_if.sv.
`timescale 1ns / 100ps

module tb;

   localparam int RAND_CMDS      = 1024;
   localparam int HOLD_AT_RESULT = 500;
   localparam int HOLD_CYCLES    = 200;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      rrdt_pkg::op_type     op;
      rrdt_pkg::handle_type handle;
      rrdt_pkg::ticks_type  delay;
      rrdt_pkg::ticks_type  period;
      bit                   drain;
      int                   gap;
   } sched_cmd_type;

   typedef struct {
      rrdt_pkg::status_type            status;
      logic [rrdt_pkg::SLOT_IDX_W-1:0] slot;
      rrdt_pkg::handle_type            run;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   rrdt_req_if req_if();
   rrdt_rsp_if rsp_if();

   round_robin_delay_task_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Predicted contents of the slot table.
   rrdt_pkg::handle_type tbl_handle [rrdt_pkg::TASK_SLOTS];
   rrdt_pkg::ticks_type  tbl_delay  [rrdt_pkg::TASK_SLOTS];
   rrdt_pkg::ticks_type  tbl_period [rrdt_pkg::TASK_SLOTS];
   int                   last_served;

   sched_cmd_type pending_cmds [$];
   sched_rsp_type expected_rsps [$];

   sched_cmd_type cur_cmd;
   bit         have_cmd;
   int         gap_left;
   int         wait_left;
   int         hold_left;
   bit         hold_done;
   bit         req_fired;
   bit         rsp_fired;
   int         idle_cycles;
   int         errors;
   int         results_seen;
   int         op_count [4];
   int         ran_count;
   int         full_count;

   // Applies one request word to the predicted table and returns its response.
   function automatic sched_rsp_type table_step(input sched_cmd_type c);
      sched_rsp_type r;
      int            hit;
      int            s;
      r   = '{status: rrdt_pkg::ST_OK, slot: '0, run: '0};
      hit = -1;
      case (c.op)
         rrdt_pkg::OP_ADD: begin
            if (c.handle == '0) begin
               r.status = rrdt_pkg::ST_BAD_HANDLE;
            end else begin
               for (int i = 0; i < rrdt_pkg::TASK_SLOTS; i++) begin
                  if (hit < 0 && tbl_handle[i] == '0) hit = i;
               end
               if (hit < 0) begin
                  r.status = rrdt_pkg::ST_FULL;
               end else begin
                  tbl_handle[hit] = c.handle;
                  tbl_delay[hit]  = c.delay;
                  tbl_period[hit] = c.period;
                  r.slot = rrdt_pkg::SLOT_IDX_W'(hit);
               end
            end
         end
         rrdt_pkg::OP_TICK: begin
            for (int i = 0; i < rrdt_pkg::TASK_SLOTS; i++) begin
               if (tbl_delay[i] != '0) tbl_delay[i] = tbl_delay[i] - 1'b1;
            end
         end
         rrdt_pkg::OP_DISPATCH: begin
            s = (last_served + 1) % rrdt_pkg::TASK_SLOTS;
            for (int i = 0; i < rrdt_pkg::TASK_SLOTS; i++) begin
               if (hit < 0 && tbl_handle[s] != '0 && tbl_delay[s] == '0) hit = s;
               s = (s + 1) % rrdt_pkg::TASK_SLOTS;
            end
            if (hit < 0) begin
               r.status = rrdt_pkg::ST_NONE;
            end else begin
               r.slot      = rrdt_pkg::SLOT_IDX_W'(hit);
               r.run       = tbl_handle[hit];
               last_served = hit;
               if (tbl_period[hit] != '0) begin
                  tbl_delay[hit] = tbl_period[hit];
               end else begin
                  tbl_handle[hit] = '0;
                  tbl_delay[hit]  = '0;
               end
            end
         end
         default: begin
            if (c.handle == '0) begin
               r.status = rrdt_pkg::ST_BAD_HANDLE;
            end else begin
               for (int i = 0; i < rrdt_pkg::TASK_SLOTS; i++) begin
                  if (hit < 0 && tbl_handle[i] == c.handle) hit = i;
               end
               if (hit < 0) begin
                  r.status = rrdt_pkg::ST_NONE;
               end else begin
                  r.slot = rrdt_pkg::SLOT_IDX_W'(hit);
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic sched_cmd_type make_cmd(input rrdt_pkg::op_type op,
                                              input rrdt_pkg::handle_type h,
                                              input rrdt_pkg::ticks_type d,
                                              input rrdt_pkg::ticks_type p);
      sched_cmd_type c;
      c = '{op: op, handle: h, delay: d, period: p, drain: 1'b0,
            gap: $urandom_range(0, 5)};
      return c;
   endfunction

   // Mostly small handles, delays and periods so that finds hit and tasks come due;
   // large add delays and long repeat periods are kept for the last quarter, since
   // such tasks hold their slot for the rest of the run.
   function automatic sched_cmd_type random_cmd(input int n);
      sched_cmd_type c;
      int            pick;
      bit            late;
      late   = (n >= RAND_CMDS * 3 / 4);
      pick   = $urandom_range(0, 99);
      c      = make_cmd(rrdt_pkg::OP_TICK, rrdt_pkg::handle_type'($urandom_range(1, 12)),
                        rrdt_pkg::ticks_type'($urandom_range(0, 3)), '0);
      if ((n / 64) % 4 == 3) c.gap = 0;
      if (pick < 30) begin
         c.op = rrdt_pkg::OP_ADD;
         if ($urandom_range(0, 19) == 0) begin
            c.handle = '0;
         end else if ($urandom_range(0, 19) == 0) begin
            c.handle = rrdt_pkg::handle_type'($urandom);
         end
         if (late ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 29) == 0)) begin
            c.period = (late && $urandom_range(0, 1) == 1)
                       ? rrdt_pkg::ticks_type'($urandom)
                       : rrdt_pkg::ticks_type'($urandom_range(1, 4));
         end
         if (late && $urandom_range(0, 7) == 0) c.delay = rrdt_pkg::ticks_type'($urandom);
      end else begin
         if (pick < 55) begin
            c.op = rrdt_pkg::OP_TICK;
         end else if (pick < 85) begin
            c.op = rrdt_pkg::OP_DISPATCH;
         end else begin
            c.op = rrdt_pkg::OP_FIND;
            if ($urandom_range(0, 19) == 0) c.handle = '0;
            else if ($urandom_range(0, 19) == 0) c.handle = rrdt_pkg::handle_type'($urandom);
         end
         // Fields that the operation ignores carry noise now and then.
         if ($urandom_range(0, 3) == 0) begin
            c.delay  = rrdt_pkg::ticks_type'($urandom);
            c.period = rrdt_pkg::ticks_type'($urandom);
            if (c.op != rrdt_pkg::OP_FIND) c.handle = rrdt_pkg::handle_type'($urandom);
         end
      end
      return c;
   endfunction

   task automatic queue_cmd(input rrdt_pkg::op_type op, input rrdt_pkg::handle_type h,
                            input rrdt_pkg::ticks_type d, input rrdt_pkg::ticks_type p);
      pending_cmds.push_back(make_cmd(op, h, d, p));
   endtask

   // Monitor, predictor and watchdog.
   always @(posedge clock) begin : monitor
      sched_cmd_type seen;
      sched_rsp_type exp_rsp;
      if (reset) begin
         req_fired   <= 1'b0;
         rsp_fired   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         rsp_fired <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            seen = '{op: rrdt_pkg::op_type'(req_if.opcode), handle: req_if.task_handle,
                     delay: req_if.delay_ticks, period: req_if.repeat_ticks,
                     drain: 1'b0, gap: 0};
            exp_rsp = table_step(seen);
            expected_rsps.push_back(exp_rsp);
            op_count[int'(req_if.opcode)]++;
            if (seen.op == rrdt_pkg::OP_DISPATCH && exp_rsp.status == rrdt_pkg::ST_OK) begin
               ran_count++;
            end
            if (exp_rsp.status == rrdt_pkg::ST_FULL) full_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response word with no request outstanding: status %0d slot %0d",
                      rsp_if.status, rsp_if.slot_index);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_if.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_if.status);
                  errors++;
               end
               if (rsp_if.slot_index !== exp_rsp.slot) begin
                  $error("slot_index: expected %0d, got %0d", exp_rsp.slot,
                         rsp_if.slot_index);
                  errors++;
               end
               if (rsp_if.run_handle !== exp_rsp.run) begin
                  $error("run_handle: expected %0h, got %0h", exp_rsp.run,
                         rsp_if.run_handle);
                  errors++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Request driver: a word marked for draining waits until every response is in.
   always @(negedge clock) begin : driver
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_fired)) begin
         if (!have_cmd && pending_cmds.size() != 0) begin
            cur_cmd  = pending_cmds.pop_front();
            have_cmd = 1'b1;
            gap_left = cur_cmd.gap;
         end
         if (have_cmd && gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (have_cmd && cur_cmd.drain && expected_rsps.size() != 0) begin
            req_if.valid <= 1'b0;
         end else if (have_cmd) begin
            req_if.opcode       <= cur_cmd.op;
            req_if.task_handle  <= cur_cmd.handle;
            req_if.delay_ticks  <= cur_cmd.delay;
            req_if.repeat_ticks <= cur_cmd.period;
            req_if.valid        <= 1'b1;
            have_cmd = 1'b0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls, stall-free stretches and one long hold-off.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            wait_left = ((results_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, 5);
            if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      sched_cmd_type c;
      req_if.valid        = 1'b0;
      req_if.opcode       = rrdt_pkg::OP_ADD;
      req_if.task_handle  = '0;
      req_if.delay_ticks  = '0;
      req_if.repeat_ticks = '0;
      rsp_if.ready        = 1'b0;
      have_cmd     = 1'b0;
      gap_left     = 0;
      wait_left    = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      errors       = 0;
      results_seen = 0;
      ran_count    = 0;
      full_count   = 0;
      last_served  = 0;
      for (int i = 0; i < 4; i++) op_count[i] = 0;
      for (int i = 0; i < rrdt_pkg::TASK_SLOTS; i++) begin
         tbl_handle[i] = '0;
         tbl_delay[i]  = '0;
         tbl_period[i] = '0;
      end

      // Empty table, invalid handles, filling up with a duplicate, then a full table.
      queue_cmd(rrdt_pkg::OP_DISPATCH, '0, '0, '0);
      queue_cmd(rrdt_pkg::OP_FIND, '0, '0, '0);
      queue_cmd(rrdt_pkg::OP_FIND, 16'd5, '0, '0);
      queue_cmd(rrdt_pkg::OP_ADD, '0, 16'd3, 16'd3);
      queue_cmd(rrdt_pkg::OP_ADD, 16'hFFFF, '0, '0);
      queue_cmd(rrdt_pkg::OP_ADD, 16'h8000, '0, '0);
      for (int h = 2; h <= 6; h++) begin
         queue_cmd(rrdt_pkg::OP_ADD, rrdt_pkg::handle_type'(h), '0, '0);
      end
      queue_cmd(rrdt_pkg::OP_ADD, 16'hFFFF, '0, '0);
      queue_cmd(rrdt_pkg::OP_ADD, 16'd9, '0, '0);
      queue_cmd(rrdt_pkg::OP_FIND, 16'hFFFF, '0, '0);
      // One-shot tasks are served round-robin and freed, wrapping back to slot 0.
      for (int i = 0; i < rrdt_pkg::TASK_SLOTS; i++) begin
         queue_cmd(rrdt_pkg::OP_DISPATCH, '0, '0, '0);
      end
      // A repeating task must count down before it is due, then it reloads.
      queue_cmd(rrdt_pkg::OP_ADD, 16'd10, 16'd1, 16'd1);
      queue_cmd(rrdt_pkg::OP_DISPATCH, '0, '0, '0);
      queue_cmd(rrdt_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_cmd(rrdt_pkg::OP_DISPATCH, '0, '0, '0);

      for (int n = 0; n < RAND_CMDS; n++) begin
         c = random_cmd(n);
         if (n == 0 || n == RAND_CMDS / 2) c.drain = 1'b1;
         pending_cmds.push_back(c);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(pending_cmds.size() == 0 && !have_cmd && !req_if.valid
               && expected_rsps.size() == 0)) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         errors++;
      end

      $display("Run: %0d requests (add %0d, tick %0d, dispatch %0d, find %0d), %0d responses",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[rrdt_pkg::OP_ADD], op_count[rrdt_pkg::OP_TICK],
               op_count[rrdt_pkg::OP_DISPATCH], op_count[rrdt_pkg::OP_FIND], results_seen);
      $display("Tasks dispatched: %0d, adds refused by a full table: %0d, mismatches: %0d",
               ran_count, full_count, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/rrdt_pkg.sv
hw/rtl/rrdt_if.sv
hw/rtl/rrdt_seq.sv
hw/rtl/round_robin_delay_task_table.sv
tb/tb.sv
